FILE: hdl/value_noise_2d_assert.svh
// ----------------------------------------------------------------------------
// value_noise_2d_assert.svh
// assertion macros shared by the value noise rtl, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef VALUE_NOISE_2D_ASSERT_SVH
`define VALUE_NOISE_2D_ASSERT_SVH

// same-cycle implication
`define VN2D_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VN2D_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/vn2d_pkg.sv
// ----------------------------------------------------------------------------
// vn2d_pkg
// types, constants and arithmetic helpers of the 2d value noise pipeline
// ----------------------------------------------------------------------------
package vn2d_pkg;

  // lattice values and blend results, -65535..65535
  typedef logic signed [16:0] lat_t;
  // scaled blend product, (b - a) * s
  typedef logic signed [34:0] bprod_t;

  localparam int unsigned NUM_STAGES = 10;

  // register indexes, decoded from paddr[2]
  localparam logic CFG_IDX_FREQUENCY  = 1'b0;
  localparam logic CFG_IDX_NOISE_SEED = 1'b1;

  localparam logic [15:0] FREQ_RESET = 16'd1704;
  localparam logic [31:0] SEED_RESET = 32'd0;

  // hash constants
  localparam logic [31:0] HASH_KX  = 32'h9e3779b1;
  localparam logic [31:0] HASH_KY  = 32'h85ebca6b;
  localparam logic [31:0] MIX_MUL1 = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL2 = 32'h846ca68b;

  localparam logic [16:0] LAT_OFFSET = 17'd65535;
  localparam logic [17:0] EASE_THREE = 18'h30000;
  localparam bprod_t      ROUND_HALF = 35'sd32768;

  // low hash half to lattice value 2h - 65535
  function automatic lat_t lattice_value(input logic [31:0] v);
    logic [15:0] h;
    logic [16:0] d;
    h = v[15:0] ^ v[31:16];
    d = {h, 1'b0} - LAT_OFFSET;
    return $signed(d);
  endfunction

  // a + round((b - a) * s / 65536), ties toward plus infinity
  function automatic lat_t blend_round(input lat_t a, input bprod_t p);
    bprod_t             r;
    logic signed [18:0] q;
    logic signed [18:0] s;
    r = p + ROUND_HALF;
    q = r[34:16];
    s = 19'(a) + q;
    return $signed(s[16:0]);
  endfunction

  // (b - a) * s
  function automatic bprod_t blend_product(input lat_t a, input lat_t b,
                                           input logic [15:0] s);
    logic signed [17:0] d;
    logic signed [16:0] ss;
    d  = 18'(b) - 18'(a);
    ss = $signed({1'b0, s});
    return 35'(d) * 35'(ss);
  endfunction

endpackage

FILE: hdl/value_noise_2d.sv
// ----------------------------------------------------------------------------
// value_noise_2d - 2d value noise, one sample point per beat
// ten register stages, stage 0 to stage 9, between input beat and result beat
// throughput: one point per cycle, a stall freezes only stages that are full
// reset: synchronous active-low, clears stage valids, frequency to 1704, seed 0
// ----------------------------------------------------------------------------
`include "value_noise_2d_assert.svh"

module value_noise_2d import vn2d_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_x_coord,
  input  logic signed [23:0] in_y_coord,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_noise_value,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // configuration registers; the user must write them only while the pipe is empty, the block does not enforce it
  // --------------------------------------------------------------------------
  logic [15:0] freq_r;
  logic [31:0] seed_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET;
      seed_r <= SEED_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_IDX_FREQUENCY:  freq_r <= pwdata[15:0];
        CFG_IDX_NOISE_SEED: seed_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_IDX_FREQUENCY:  prdata = {16'd0, freq_r};
      CFG_IDX_NOISE_SEED: prdata = seed_r;
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control: each stage advances when empty or when the next advances
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] adv;
  logic                  in_acc;
  logic                  out_acc;

  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NUM_STAGES-1];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // stage 0: scale the point, p = coord * frequency, signed q16.24
  // --------------------------------------------------------------------------
  logic signed [40:0] px_r, py_r;
  logic signed [40:0] px_nxt, py_nxt;
  logic signed [16:0] freq_s;

  assign freq_s = $signed({1'b0, freq_r});
  assign px_nxt = 41'(in_x_coord) * 41'(freq_s);
  assign py_nxt = 41'(in_y_coord) * 41'(freq_s);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: split into cell and fraction, square the fraction, cell * key
  // --------------------------------------------------------------------------
  logic [15:0] fx_r, fy_r;
  logic [31:0] ttx_r, tty_r;
  logic [31:0] mx_r, my_r;
  logic [15:0] fx_nxt, fy_nxt;
  logic [31:0] ttx_nxt, tty_nxt;
  logic [31:0] mx_nxt, my_nxt;
  logic [31:0] cxw, cyw;

  // cell is floor(p), always within 16 signed bits
  assign cxw     = {{16{px_r[39]}}, px_r[39:24]};
  assign cyw     = {{16{py_r[39]}}, py_r[39:24]};
  assign fx_nxt  = px_r[23:8];
  assign fy_nxt  = py_r[23:8];
  assign ttx_nxt = {16'd0, fx_nxt} * {16'd0, fx_nxt};
  assign tty_nxt = {16'd0, fy_nxt} * {16'd0, fy_nxt};
  assign mx_nxt  = cxw * HASH_KX;
  assign my_nxt  = cyw * HASH_KY;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
      ttx_r <= ttx_nxt;
      tty_r <= tty_nxt;
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: smoothstep t*t*(3 - 2t), corner hash mix and first fold
  // corner order: (cx,cy) (cx+1,cy) (cx,cy+1) (cx+1,cy+1)
  // (c+1)*k = c*k + k, so the neighbor keys are one add away
  // --------------------------------------------------------------------------
  logic [15:0] sx2_r, sy2_r;
  logic [31:0] v1_r [4];
  logic [15:0] sx2_nxt, sy2_nxt;
  logic [31:0] v1_nxt [4];
  logic [49:0] ex, ey;
  logic [17:0] wx, wy;

  assign wx      = EASE_THREE - {1'b0, fx_r, 1'b0};
  assign wy      = EASE_THREE - {1'b0, fy_r, 1'b0};
  assign ex      = 50'(ttx_r) * 50'(wx);
  assign ey      = 50'(tty_r) * 50'(wy);
  assign sx2_nxt = ex[47:32];
  assign sy2_nxt = ey[47:32];

  always_comb begin
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] h;
    for (int c = 0; c < 4; c++) begin
      hx        = c[0] ? (mx_r + HASH_KX) : mx_r;
      hy        = c[1] ? (my_r + HASH_KY) : my_r;
      h         = seed_r ^ hx ^ hy;
      v1_nxt[c] = h ^ (h >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sx2_r <= sx2_nxt;
      sy2_r <= sy2_nxt;
      for (int c = 0; c < 4; c++) begin
        v1_r[c] <= v1_nxt[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: first avalanche multiply
  // --------------------------------------------------------------------------
  logic [15:0] sx3_r, sy3_r;
  logic [31:0] v2_r [4];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      for (int c = 0; c < 4; c++) begin
        v2_r[c] <= v1_r[c] * MIX_MUL1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: fold by 15, second avalanche multiply
  // --------------------------------------------------------------------------
  logic [15:0] sx4_r, sy4_r;
  logic [31:0] v4_r [4];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      for (int c = 0; c < 4; c++) begin
        v4_r[c] <= (v2_r[c] ^ (v2_r[c] >> 15)) * MIX_MUL2;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: last fold, lattice value 2h - 65535
  // --------------------------------------------------------------------------
  logic [15:0] sx5_r, sy5_r;
  lat_t        lat_r [4];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sx5_r <= sx4_r;
      sy5_r <= sy4_r;
      for (int c = 0; c < 4; c++) begin
        lat_r[c] <= lattice_value(v4_r[c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: x blend products for the top and bottom rows
  // --------------------------------------------------------------------------
  logic [15:0] sy6_r;
  lat_t        a_top_r, a_bot_r;
  bprod_t      p_top_r, p_bot_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      sy6_r   <= sy5_r;
      a_top_r <= lat_r[0];
      a_bot_r <= lat_r[2];
      p_top_r <= blend_product(lat_r[0], lat_r[1], sx5_r);
      p_bot_r <= blend_product(lat_r[2], lat_r[3], sx5_r);
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: round and add, row values
  // --------------------------------------------------------------------------
  logic [15:0] sy7_r;
  lat_t        top_r, bot_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      sy7_r <= sy6_r;
      top_r <= blend_round(a_top_r, p_top_r);
      bot_r <= blend_round(a_bot_r, p_bot_r);
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: y blend product
  // --------------------------------------------------------------------------
  lat_t   top8_r;
  bprod_t p_mix_r;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      top8_r  <= top_r;
      p_mix_r <= blend_product(top_r, bot_r, sy7_r);
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: final round and add, output register
  // --------------------------------------------------------------------------
  lat_t out_r;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      out_r <= blend_round(top8_r, p_mix_r);
    end
  end

  assign out_noise_value = out_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // items in flight change only by accepted beats
  `VN2D_ASSERT_NEXT(a_item_count, 1'b1, $countones(v_r) == $past($countones(v_r)) + $past(32'(in_acc)) - $past(32'(out_acc)), "pipe lost or duplicated an item")
  // a full pipe with a stalled output refuses input
  `VN2D_ASSERT_NOW(a_full_stall, (&v_r) && out_stall, in_stall, "full pipe took an input beat")
  // blended result stays within the lattice range
  `VN2D_ASSERT_NOW(a_out_range, out_valid, (out_noise_value >= -17'sd65535) && (out_noise_value <= 17'sd65535), "noise value out of range")

endmodule
